### hdl/nearest_segment_crossing_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the nearest segment crossing block
// Shared helpers that wrap concurrent assertions on clk with reset disable.
// ---------------------------------------------------------------------------
`ifndef NEAREST_SEGMENT_CROSSING_DEFINES_SVH
`define NEAREST_SEGMENT_CROSSING_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define NSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/nsc_pkg.sv
// ---------------------------------------------------------------------------
// nsc_pkg
// Shared constants and controller to datapath command and status types.
// ---------------------------------------------------------------------------
package nsc_pkg;

	localparam int DEF_MAX_SEGMENTS    = 256;
	localparam int DEF_COORD_FRAC_BITS = 16;
	localparam int CFG_W               = 16;
	localparam int DIV_STEPS           = 32;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_MIN_MOVE_SQ      = 1'b0;
	localparam logic REG_PARALLEL_EPSILON = 1'b1;

	typedef enum logic [3:0] {
		MUL_XX,
		MUL_YY,
		MUL_AXCDY,
		MUL_AYCDX,
		MUL_DXCDY,
		MUL_DYCDX,
		MUL_DXAY,
		MUL_DYAX,
		MUL_LX,
		MUL_LY,
		MUL_LZ
	} mul_sel_t;

	typedef enum logic [2:0] {
		SUM_NONE,
		SUM_LOAD,
		SUM_ADD,
		SUM_DEN,
		SUM_NT,
		SUM_NU
	} sum_op_t;

	typedef struct packed {
		logic     capture;
		logic     wr_entry;
		logic     idx_clr;
		logic     idx_inc;
		logic     ent_load;
		mul_sel_t mul_sel;
		sum_op_t  sum_op;
		logic     div_init;
		logic     div_step;
		logic     best_upd;
		logic     lerp_x;
		logic     lerp_y;
		logic     lerp_z;
	} nsc_cmd_t;

	typedef struct packed {
		logic tiny_move;
		logic ent_valid;
		logic pass;
		logic div_eq;
		logic last;
		logic any;
	} nsc_sts_t;

endpackage

### hdl/nsc_ram.sv
// ---------------------------------------------------------------------------
// nsc_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module nsc_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/nsc_ctrl.sv
// ---------------------------------------------------------------------------
// nsc_ctrl
// Sequencer for writes, the move length check, the entry walk and lerp.
// ---------------------------------------------------------------------------
module nsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	output logic              busy,
	output logic              done,
	output nsc_pkg::nsc_cmd_t cmd,
	input  nsc_pkg::nsc_sts_t sts
);
	import nsc_pkg::*;

	typedef enum logic [23:0] {
		S_IDLE = 24'h000001,
		S_MV1  = 24'h000002,
		S_MV2  = 24'h000004,
		S_MV3  = 24'h000008,
		S_MV4  = 24'h000010,
		S_RD   = 24'h000020,
		S_C0   = 24'h000040,
		S_M1   = 24'h000080,
		S_M2   = 24'h000100,
		S_M3   = 24'h000200,
		S_M4   = 24'h000400,
		S_M5   = 24'h000800,
		S_M6   = 24'h001000,
		S_M7   = 24'h002000,
		S_TEST = 24'h004000,
		S_DIV  = 24'h008000,
		S_BEST = 24'h010000,
		S_NEXT = 24'h020000,
		S_L1   = 24'h040000,
		S_L2   = 24'h080000,
		S_L3   = 24'h100000,
		S_L4   = 24'h200000,
		S_DONE = 24'h400000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		cmd.mul_sel = MUL_XX;
		cmd.sum_op  = SUM_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (op == OP_QUERY) begin
						cmd.capture = 1'b1;
						state_d     = S_MV1;
					end else begin
						cmd.wr_entry = 1'b1;
					end
				end
			end
			S_MV1: begin
				cmd.mul_sel = MUL_XX;
				state_d     = S_MV2;
			end
			S_MV2: begin
				cmd.mul_sel = MUL_YY;
				cmd.sum_op  = SUM_LOAD;
				state_d     = S_MV3;
			end
			S_MV3: begin
				cmd.sum_op = SUM_ADD;
				state_d    = S_MV4;
			end
			S_MV4: begin
				cmd.idx_clr = 1'b1;
				state_d     = sts.tiny_move ? S_DONE : S_RD;
			end
			S_RD: begin
				state_d = S_C0;
			end
			S_C0: begin
				cmd.ent_load = 1'b1;
				state_d      = sts.ent_valid ? S_M1 : S_NEXT;
			end
			S_M1: begin
				cmd.mul_sel = MUL_AXCDY;
				state_d     = S_M2;
			end
			S_M2: begin
				cmd.mul_sel = MUL_AYCDX;
				cmd.sum_op  = SUM_LOAD;
				state_d     = S_M3;
			end
			S_M3: begin
				cmd.mul_sel = MUL_DXCDY;
				cmd.sum_op  = SUM_DEN;
				state_d     = S_M4;
			end
			S_M4: begin
				cmd.mul_sel = MUL_DYCDX;
				cmd.sum_op  = SUM_LOAD;
				state_d     = S_M5;
			end
			S_M5: begin
				cmd.mul_sel = MUL_DXAY;
				cmd.sum_op  = SUM_NT;
				state_d     = S_M6;
			end
			S_M6: begin
				cmd.mul_sel = MUL_DYAX;
				cmd.sum_op  = SUM_LOAD;
				state_d     = S_M7;
			end
			S_M7: begin
				cmd.sum_op = SUM_NU;
				state_d    = S_TEST;
			end
			S_TEST: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				if (!sts.pass) begin
					state_d = S_NEXT;
				end else if (sts.div_eq) begin
					state_d = S_BEST;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = S_BEST;
				end
			end
			S_BEST: begin
				cmd.best_upd = 1'b1;
				state_d      = S_NEXT;
			end
			S_NEXT: begin
				if (sts.last) begin
					state_d = sts.any ? S_L1 : S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_L1: begin
				cmd.mul_sel = MUL_LX;
				state_d     = S_L2;
			end
			S_L2: begin
				cmd.mul_sel = MUL_LY;
				cmd.lerp_x  = 1'b1;
				state_d     = S_L3;
			end
			S_L3: begin
				cmd.mul_sel = MUL_LZ;
				cmd.lerp_y  = 1'b1;
				state_d     = S_L4;
			end
			S_L4: begin
				cmd.lerp_z = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hdl/nsc_dp.sv
// ---------------------------------------------------------------------------
// nsc_dp
// Datapath: segment store, shared multiplier, cross sums, divider, lerp.
// ---------------------------------------------------------------------------
module nsc_dp #(
	parameter int MAX_SEGMENTS    = nsc_pkg::DEF_MAX_SEGMENTS,
	parameter int COORD_FRAC_BITS = nsc_pkg::DEF_COORD_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [nsc_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic [7:0]                  entry_index,
	input  logic                        entry_valid,
	input  logic signed [31:0]          p0_x,
	input  logic signed [31:0]          p0_y,
	input  logic signed [31:0]          p0_z,
	input  logic signed [31:0]          p1_x,
	input  logic signed [31:0]          p1_y,
	input  logic signed [31:0]          p1_z,
	input  nsc_pkg::nsc_cmd_t           cmd,
	output nsc_pkg::nsc_sts_t           sts,
	output logic                        hit,
	output logic signed [31:0]          hit_x,
	output logic signed [31:0]          hit_y,
	output logic signed [31:0]          hit_z
);
	import nsc_pkg::*;

	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	function automatic logic [32:0] abs33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic [67:0] abs68(input logic signed [67:0] v);
		return v[67] ? 68'(-v) : 68'(v);
	endfunction

	function automatic logic in_unit(input logic signed [67:0] num,
		input logic signed [67:0] den);
		if (num == '0) begin
			return 1'b1;
		end
		if (num[67] != den[67]) begin
			return 1'b0;
		end
		return abs68(num) <= abs68(den);
	endfunction

	function automatic logic [31:0] lerp(input logic [31:0] start,
		input logic neg, input logic [67:0] prod);
		logic [63:0] rnd;
		rnd = prod[63:0] + 64'h0000_0000_8000_0000;
		return neg ? (start - rnd[63:32]) : (start + rnd[63:32]);
	endfunction

	// Configuration registers.
	logic [CFG_W-1:0] min_move_sq_q, par_eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_move_sq_q <= '0;
			par_eps_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_MOVE_SQ:      min_move_sq_q <= cfg_wdata;
				REG_PARALLEL_EPSILON: par_eps_q     <= cfg_wdata;
				default:              min_move_sq_q <= min_move_sq_q;
			endcase
		end
	end

	// Segment store and valid bits.
	logic [31:0]       ei32;
	logic              in_range;
	logic [IW-1:0]     idx_q;
	logic [127:0]      rdata;
	logic [MAX_SEGMENTS-1:0] valid_q;

	assign ei32     = 32'(entry_index);
	assign in_range = ei32 < 32'(MAX_SEGMENTS);

	nsc_ram #(
		.WIDTH (128),
		.DEPTH (MAX_SEGMENTS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_entry && in_range),
		.waddr (ei32[IW-1:0]),
		.wdata ({p0_x, p0_y, p1_x, p1_y}),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_entry && in_range) begin
			valid_q[ei32[IW-1:0]] <= entry_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// Query operands.
	logic signed [31:0] ax_q, ay_q, az_q;
	logic signed [32:0] abx_q, aby_q, dz_q;
	logic signed [32:0] cdx_q, cdy_q, dx_q, dy_q;
	logic signed [31:0] sax, say, sbx, sby;

	assign sax = rdata[127:96];
	assign say = rdata[95:64];
	assign sbx = rdata[63:32];
	assign sby = rdata[31:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ax_q  <= p0_x;
			ay_q  <= p0_y;
			az_q  <= p0_z;
			abx_q <= 33'(p1_x) - 33'(p0_x);
			aby_q <= 33'(p1_y) - 33'(p0_y);
			dz_q  <= 33'(p1_z) - 33'(p0_z);
		end
		if (cmd.ent_load) begin
			cdx_q <= 33'(sbx) - 33'(sax);
			cdy_q <= 33'(sby) - 33'(say);
			dx_q  <= 33'(sax) - 33'(ax_q);
			dy_q  <= 33'(say) - 33'(ay_q);
		end
	end

	// Shared multiplier, registered every cycle.
	logic signed [33:0] ma, mb;
	logic signed [67:0] prod_q;
	logic        [32:0] best_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_XX:    begin ma = 34'(abx_q); mb = 34'(abx_q); end
			MUL_YY:    begin ma = 34'(aby_q); mb = 34'(aby_q); end
			MUL_AXCDY: begin ma = 34'(abx_q); mb = 34'(cdy_q); end
			MUL_AYCDX: begin ma = 34'(aby_q); mb = 34'(cdx_q); end
			MUL_DXCDY: begin ma = 34'(dx_q);  mb = 34'(cdy_q); end
			MUL_DYCDX: begin ma = 34'(dy_q);  mb = 34'(cdx_q); end
			MUL_DXAY:  begin ma = 34'(dx_q);  mb = 34'(aby_q); end
			MUL_DYAX:  begin ma = 34'(dy_q);  mb = 34'(abx_q); end
			MUL_LX:    begin ma = {1'b0, abs33(abx_q)}; mb = {1'b0, best_q}; end
			MUL_LY:    begin ma = {1'b0, abs33(aby_q)}; mb = {1'b0, best_q}; end
			MUL_LZ:    begin ma = {1'b0, abs33(dz_q)};  mb = {1'b0, best_q}; end
			default:   begin ma = '0; mb = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	// Cross product sums.
	logic signed [67:0] sum_q, den_q, nt_q, nu_q;

	always_ff @(posedge clk) begin
		case (cmd.sum_op)
			SUM_LOAD: sum_q <= prod_q;
			SUM_ADD:  sum_q <= sum_q + prod_q;
			SUM_DEN:  den_q <= sum_q - prod_q;
			SUM_NT:   nt_q  <= sum_q - prod_q;
			SUM_NU:   nu_q  <= sum_q - prod_q;
			default:  sum_q <= sum_q;
		endcase
	end

	logic [67:0] den_abs, nt_abs, eps_w, mms_w;
	logic [32:0] mx, my;

	assign den_abs = abs68(den_q);
	assign nt_abs  = abs68(nt_q);
	assign eps_w   = 68'(par_eps_q) << COORD_FRAC_BITS;
	assign mms_w   = 68'(min_move_sq_q) << COORD_FRAC_BITS;
	assign mx      = abs33(abx_q);
	assign my      = abs33(aby_q);

	// Restoring divider, one quotient bit a cycle.
	logic [69:0] rem_q, rem2;
	logic [67:0] dvs_q;
	logic [32:0] quo_q;
	logic        ge;
	logic        any_q;

	assign rem2 = {rem_q[68:0], 1'b0};
	assign ge   = rem2 >= {2'b00, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= {2'b00, nt_abs};
			dvs_q <= den_abs;
			quo_q <= (nt_abs == den_abs) ? 33'h1_0000_0000 : '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? (rem2 - {2'b00, dvs_q}) : rem2;
			quo_q <= {quo_q[31:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (cmd.capture) begin
			any_q <= 1'b0;
		end else if (cmd.best_upd && (!any_q || quo_q < best_q)) begin
			any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.best_upd && (!any_q || quo_q < best_q)) begin
			best_q <= quo_q;
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit   <= 1'b0;
			hit_x <= '0;
			hit_y <= '0;
			hit_z <= '0;
		end else if (cmd.capture) begin
			hit   <= 1'b0;
			hit_x <= '0;
			hit_y <= '0;
			hit_z <= '0;
		end else begin
			if (cmd.lerp_x) begin
				hit   <= 1'b1;
				hit_x <= lerp(ax_q, abx_q[32], prod_q);
			end
			if (cmd.lerp_y) begin
				hit_y <= lerp(ay_q, aby_q[32], prod_q);
			end
			if (cmd.lerp_z) begin
				hit_z <= lerp(az_q, dz_q[32], prod_q);
			end
		end
	end

	// Status toward the controller.
	assign sts.tiny_move = (mx[32:31] == 2'b00) && (my[32:31] == 2'b00) &&
		(68'(sum_q) < mms_w);
	assign sts.ent_valid = valid_q[idx_q];
	assign sts.pass      = (den_abs > eps_w) && in_unit(nt_q, den_q) &&
		in_unit(nu_q, den_q);
	assign sts.div_eq    = (nt_abs == den_abs);
	assign sts.last      = (32'(idx_q) == 32'(MAX_SEGMENTS - 1));
	assign sts.any       = any_q;

endmodule

### hdl/nearest_segment_crossing.sv
// ---------------------------------------------------------------------------
// nearest_segment_crossing
// Wall segment table with a nearest crossing query for a 3D movement.
// ---------------------------------------------------------------------------
// A write item (op 0) never raises busy; it stores the segment ends and the
// valid mark of one entry, and an index at or beyond MAX_SEGMENTS is dropped.
// A query item (op 1) raises busy until its single result is shown: done is
// high for exactly one cycle with hit, hit_x, hit_y and hit_z, and the
// receiver must take the item in that cycle because the block cannot hold
// it. A query whose squared XY movement is below min_move_sq ends without
// walking the table. Otherwise the controller walks every entry of the table
// in order through one shared 34 by 34 multiplier and a one bit per cycle
// restoring divider; invalid entries skip the multiplier, and a crossing
// that lies exactly at the movement end skips the divider. The divider sets
// the cost of a crossing entry, the multiplier sequence that of every other
// valid entry. The segment table sits in a RAM that needs no clearing; only
// the valid bits are reset. Configuration writes take effect at once and are
// meant for idle periods.
// ---------------------------------------------------------------------------
`include "nearest_segment_crossing_defines.svh"

module nearest_segment_crossing #(
	parameter int MAX_SEGMENTS    = nsc_pkg::DEF_MAX_SEGMENTS,
	parameter int COORD_FRAC_BITS = nsc_pkg::DEF_COORD_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [nsc_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      op,
	input  logic [7:0]                entry_index,
	input  logic                      entry_valid,
	input  logic signed [31:0]        p0_x,
	input  logic signed [31:0]        p0_y,
	input  logic signed [31:0]        p0_z,
	input  logic signed [31:0]        p1_x,
	input  logic signed [31:0]        p1_y,
	input  logic signed [31:0]        p1_z,
	output logic                      done,
	output logic                      hit,
	output logic signed [31:0]        hit_x,
	output logic signed [31:0]        hit_y,
	output logic signed [31:0]        hit_z
);
	import nsc_pkg::*;

	// Commands flow from the sequencer, status flows back.
	nsc_cmd_t cmd;
	nsc_sts_t sts;

	nsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	nsc_dp #(
		.MAX_SEGMENTS    (MAX_SEGMENTS),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.entry_index (entry_index),
		.entry_valid (entry_valid),
		.p0_x        (p0_x),
		.p0_y        (p0_y),
		.p0_z        (p0_z),
		.p1_x        (p1_x),
		.p1_y        (p1_y),
		.p1_z        (p1_z),
		.cmd         (cmd),
		.sts         (sts),
		.hit         (hit),
		.hit_x       (hit_x),
		.hit_y       (hit_y),
		.hit_z       (hit_z)
	);

	// A query that is accepted keeps the block busy in the next cycle.
	`NSC_ASSERT_NXT(a_query_busy, start && !busy && (op == OP_QUERY), busy, "query not started")
	// The result strobe lasts one cycle and returns the block to idle.
	`NSC_ASSERT_NXT(a_done_idle, done, !busy && !done, "done not followed by idle")
	// A miss reports a zero point.
	`NSC_ASSERT_IMP(a_miss_zero, done && !hit, {hit_x, hit_y, hit_z} == '0, "miss point not zero")
	// A write never raises busy.
	`NSC_ASSERT_NXT(a_write_idle, start && !busy && (op == OP_WRITE), !busy, "write raised busy")

endmodule
